// ----- src/sus_pkg.sv -----
// Shared types and constants for the sorted unique set core.
// Used by the interfaces, the cell, the top level and the checker.
package sus_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 32;
    localparam int OUT_W        = 7;

    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_INSERT = 2'd0;
    localparam t_cmd CMD_REMOVE = 2'd1;

    typedef struct packed {
        logic                    insert_en;
        logic                    remove_en;
        logic signed [KEY_W-1:0] key;
    } t_ctrl;

    typedef struct packed {
        logic signed [KEY_W-1:0] entry;
        logic                    valid;
        logic                    lt;
    } t_link;

endpackage

// ----- src/sus_if.sv -----
// Valid/ready channel interfaces for commands and results.
// Depends on sus_pkg for the command type and widths.
interface sus_cmd_if;
    logic                            valid;
    logic                            ready;
    sus_pkg::t_cmd                   cmd;
    logic signed [sus_pkg::KEY_W-1:0] key_value;

    modport source (output valid, cmd, key_value, input ready);
    modport sink   (input valid, cmd, key_value, output ready);
endinterface

interface sus_res_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [sus_pkg::OUT_W-1:0]   position;
    logic [sus_pkg::OUT_W-1:0]   member_count;
    logic                        status;

    modport source (output valid, found, position, member_count, status, input ready);
    modport sink   (input valid, found, position, member_count, status, output ready);
endinterface

// ----- src/sorted_unique_set_core.sv -----
// Sorted unique set core: a chain of CAPACITY cells holding distinct signed keys in
// ascending order, with a registered result stage.
// Depends on sus_pkg, sus_if and sus_cell.
//
// Usage:
//   i_cmd carries one command item (insert, remove or lookup with a key). All cells
//   compare the key against their entry in parallel; the cell at the sorted boundary
//   takes the key on insert, and the cells above it shift one place up (insert) or
//   down (remove) in the same cycle.
//   o_res carries one result item per command: found, position, member count after
//   the command, and a status that flags an insert refused by a full store.
//   The result is registered and is valid in the cycle after acceptance.
//   Throughput is one command per cycle while results are taken without stalls,
//   set by the single compare-and-shift step of the chain. The result register
//   frees itself as the result is taken, so a new command is accepted in the same
//   cycle that the previous result leaves. When the receiver stalls, the result is
//   held and i_cmd.ready stays low until it is taken.
//   Reset empties the set and drops any pending result.
module sorted_unique_set_core #(
    parameter int CAPACITY = sus_pkg::CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sus_cmd_if.sink    i_cmd,
    sus_res_if.source  o_res
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int OW = sus_pkg::OUT_W;

    sus_pkg::t_ctrl  w_ctrl;
    sus_pkg::t_link  w_link  [CAPACITY];
    sus_pkg::t_link  w_left_edge;
    sus_pkg::t_link  w_right_edge;
    logic [CAPACITY-1:0] w_eq;
    logic [CAPACITY-1:0] w_bound;

    logic          w_accept;
    logic          w_found;
    logic          w_full;
    logic [CW-1:0] w_enc;
    logic [CW-1:0] w_pos;
    logic [CW+OW-1:0] w_pos_ext;
    logic [CW+OW-1:0] w_cnt_ext;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    logic          r_found;
    logic          r_status;
    logic [OW-1:0] r_position;
    logic [OW-1:0] r_member_count;

    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    assign w_left_edge.entry  = '0;
    assign w_left_edge.valid  = 1'b1;
    assign w_left_edge.lt     = 1'b1;
    assign w_right_edge.entry = '0;
    assign w_right_edge.valid = 1'b0;
    assign w_right_edge.lt    = 1'b0;

    assign w_found = |w_eq;
    assign w_full  = (r_count == CW'(CAPACITY));

    assign w_ctrl.key       = i_cmd.key_value;
    assign w_ctrl.insert_en = w_accept && (i_cmd.cmd == sus_pkg::CMD_INSERT)
                              && !w_found && !w_full;
    assign w_ctrl.remove_en = w_accept && (i_cmd.cmd == sus_pkg::CMD_REMOVE) && w_found;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        sus_pkg::t_link w_l;
        sus_pkg::t_link w_r;
        if (g == 0) begin : g_first
            assign w_l = w_left_edge;
        end else begin : g_mid_l
            assign w_l = w_link[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_r = w_right_edge;
        end else begin : g_mid_r
            assign w_r = w_link[g+1];
        end
        sus_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_left  (w_l),
            .i_right (w_r),
            .o_link  (w_link[g]),
            .o_eq    (w_eq[g]),
            .o_bound (w_bound[g])
        );
    end

    always_comb begin
        w_enc = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_enc = w_enc | (w_bound[i] ? CW'(i) : '0);
        end
    end

    assign w_pos = (|w_bound) ? w_enc : CW'(CAPACITY);

    always_comb begin
        n_count = r_count;
        if (w_ctrl.insert_en) begin
            n_count = r_count + 1'b1;
        end else if (w_ctrl.remove_en) begin
            n_count = r_count - 1'b1;
        end
    end

    assign w_pos_ext = {{OW{1'b0}}, w_pos};
    assign w_cnt_ext = {{OW{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_found        <= w_found;
            r_position     <= w_pos_ext[OW-1:0];
            r_member_count <= w_cnt_ext[OW-1:0];
            r_status       <= (i_cmd.cmd == sus_pkg::CMD_INSERT) && !w_found && w_full;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.found        = r_found;
    assign o_res.position     = r_position;
    assign o_res.member_count = r_member_count;
    assign o_res.status       = r_status;

endmodule

// ----- src/sus_cell.sv -----
// One storage cell of the sorted chain: holds one entry and its valid bit.
// Depends on sus_pkg for the control and neighbour link structs.
module sus_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sus_pkg::t_ctrl i_ctrl,
    input  sus_pkg::t_link i_left,
    input  sus_pkg::t_link i_right,
    output sus_pkg::t_link o_link,
    output logic           o_eq,
    output logic           o_bound
);

    logic signed [sus_pkg::KEY_W-1:0] r_entry;
    logic signed [sus_pkg::KEY_W-1:0] n_entry;
    logic                             r_valid;
    logic                             n_valid;
    logic                             w_lt;

    assign w_lt    = r_valid && (r_entry < i_ctrl.key);
    assign o_eq    = r_valid && (r_entry == i_ctrl.key);
    assign o_bound = !w_lt && i_left.lt;

    assign o_link.entry = r_entry;
    assign o_link.valid = r_valid;
    assign o_link.lt    = w_lt;

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_ctrl.insert_en && !w_lt) begin
            n_entry = o_bound ? i_ctrl.key : i_left.entry;
            n_valid = r_valid | i_left.valid;
        end else if (i_ctrl.remove_en && !w_lt) begin
            n_entry = i_right.entry;
            n_valid = i_right.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ----- src/sus_check.sv -----
// Port-level assertions for the sorted unique set core, and the bind that attaches them.
// Depends on sus_pkg and on the ports of sorted_unique_set_core.
module sus_check #(
    parameter int CAPACITY = sus_pkg::CAPACITY_DEF
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic                      i_found,
    input logic                      i_status,
    input logic [sus_pkg::OUT_W-1:0] i_member_count
);

    localparam logic [sus_pkg::OUT_W-1:0] CAP_LO = sus_pkg::OUT_W'(CAPACITY);

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("An accepted item produced no result in the next cycle.");

    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_member_count)))
        else $error("A stalled result changed or vanished.");

    a_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status) |-> (!i_found && (i_member_count == CAP_LO)))
        else $error("A full status was given while the store was not full.");

    a_reset : assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("A result was shown straight after reset.");

endmodule

bind sorted_unique_set_core sus_check #(.CAPACITY(CAPACITY)) u_sus_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_cmd.valid),
    .i_in_ready     (i_cmd.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_found        (o_res.found),
    .i_status       (o_res.status),
    .i_member_count (o_res.member_count)
);
